// ----- src/rpfe_pkg.sv -----
// Shared types and constants of the polyline resampler.
package rpfe_pkg;

   localparam int NUM_AXES    = 3;
   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int HALF_W      = 17;
   localparam int SQP_W       = DIFF_W + HALF_W;
   localparam int SUMSQ_W     = 2 * DIFF_W;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int LEN_W       = ROOT_W + 1;
   localparam int TRAV_W      = 32;
   localparam int REACH_W     = TRAV_W + 2;
   localparam int SQ_STEPS    = 2 * NUM_AXES;
   localparam int SQ_STEP_W   = $clog2(SQ_STEPS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int SEARCH_W = 14;
   localparam int SPACE_W  = 11;
   localparam int CSR_W    = SEARCH_W;

   localparam logic [SEARCH_W-1:0] SEARCH_MAX    = 14'd10000;
   localparam logic [SEARCH_W-1:0] SEARCH_RESET  = 14'd10000;
   localparam logic [SPACE_W-1:0]  SPACING_MIN   = 11'd600;
   localparam logic [SPACE_W-1:0]  SPACING_MAX   = 11'd2000;
   localparam logic [SPACE_W-1:0]  SPACING_RESET = 11'd600;

   typedef enum logic {
      CSR_SEARCH_DISTANCE = 1'b0,
      CSR_SPACING         = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      route_start;
      logic                      route_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      run_last;
   } rsp_payload_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_SEGMENT = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               route_end;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } queue_wr_type;

   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } queue_rd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_PREP,
      ST_ROOT,
      ST_REACH,
      ST_END_POINT,
      ST_CHECK,
      ST_LERP,
      ST_POINT,
      ST_FINISH
   } back_state_type;

endpackage

// ----- src/resample_polyline_from_end.sv -----
// Top level: configuration registers and front, queue and back end of the resampler.
// A route-opening item is taken straight from the idle state; a segment is squared axis by axis,
// then its length is found by the square root loop, and each emitted point passes the lane divider.
// Up to 4 items queue between front and back, so the input keeps flowing meanwhile.
// The square root loop and the per-point divider set the rate; one segment at a time.
// Synchronous active-high reset restores the configuration defaults and closes any route.
module resample_polyline_from_end import rpfe_pkg::*; #(
   parameter int FRACTION_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic [SEARCH_W-1:0] search_ff;
   logic [SEARCH_W-1:0] search_in;
   logic [SPACE_W-1:0]  spacing_ff;
   logic [SPACE_W-1:0]  spacing_in;
   logic [SEARCH_W-1:0] search_raw;
   logic [SPACE_W-1:0]  spacing_raw;

   queue_wr_type q_wr;
   queue_rd_type q_rd;
   logic         q_full;
   logic         q_pop;

   assign search_raw  = csr_wdata[SEARCH_W-1:0];
   assign spacing_raw = csr_wdata[SPACE_W-1:0];

   // saturate writes to the legal ranges
   always_comb begin
      search_in  = search_ff;
      spacing_in = spacing_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_DISTANCE: begin
               search_in = (search_raw > SEARCH_MAX) ? SEARCH_MAX : search_raw;
            end
            CSR_SPACING: begin
               if (spacing_raw < SPACING_MIN) begin
                  spacing_in = SPACING_MIN;
               end else if (spacing_raw > SPACING_MAX) begin
                  spacing_in = SPACING_MAX;
               end else begin
                  spacing_in = spacing_raw;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff  <= SEARCH_RESET;
         spacing_ff <= SPACING_RESET;
      end else begin
         search_ff  <= search_in;
         spacing_ff <= spacing_in;
      end
   end

   // accept and classify each transfer on the request side
   rpfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_wr        (q_wr)
   );

   // decouple the two halves
   rpfe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_rd   (q_rd)
   );

   // measure, step the marks and emit each result transfer
   rpfe_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_rd            (q_rd),
      .q_pop           (q_pop),
      .search_distance (search_ff),
      .spacing         (spacing_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

// ----- src/rpfe_lane.sv -----
// One axis lane: offset product, rounded restoring division and step from the base point.
module rpfe_lane import rpfe_pkg::*; #(
   parameter int MARK_W = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIFF_W-1:0]  d_mag,
   input  logic               d_neg,
   input  logic [COORD_W-1:0] base,
   input  logic [MARK_W-1:0]  off,
   input  logic [LEN_W-1:0]   len,
   output lane_status_type    status,
   output logic [COORD_W-1:0] result
);

   localparam int PROD_W = DIFF_W + MARK_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   logic              mul_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  num_in;
   logic [LEN_W-1:0]  rem_ff;
   logic [LEN_W-1:0]  rem_in;
   logic [LEN_W:0]    rem_sh;
   logic              ge;
   logic [COORD_W-1:0] quot;

   // one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, len};
      rem_in = ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
      num_in = {num_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         mul_ff  <= start;
         done_ff <= (cnt_ff == CNT_W'(1));
         if (mul_ff) begin
            cnt_ff <= CNT_W'(NUM_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(d_mag) * PROD_W'(off);
      end
      if (mul_ff) begin
         // add half the divisor to round to nearest
         num_ff <= NUM_W'(prod_ff) + NUM_W'(len >> 1);
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign quot        = num_ff[COORD_W-1:0];
   assign result      = d_neg ? (base - quot) : (base + quot);
   assign status.busy = mul_ff || (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// ----- src/rpfe_front.sv -----
// Front end: accept route points, track the open route and queue work for the back end.
module rpfe_front import rpfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            q_full,
   output queue_wr_type    q_wr
);

   logic route_open_ff;
   logic route_open_in;
   logic accept;

   always_comb begin
      accept        = req_valid && !q_full;
      route_open_in = route_open_ff;
      q_wr.push     = 1'b0;
      q_wr.cmd.op   = OP_SEGMENT;
      q_wr.cmd.route_end = req_payload.route_end;
      q_wr.cmd.x    = req_payload.point_x;
      q_wr.cmd.y    = req_payload.point_y;
      q_wr.cmd.z    = req_payload.point_z;
      if (accept) begin
         if (req_payload.route_start) begin
            // a one-point route opens and closes at once: drop it
            q_wr.cmd.op   = OP_START;
            q_wr.push     = !req_payload.route_end;
            route_open_in = !req_payload.route_end;
         end else if (route_open_ff) begin
            q_wr.push = 1'b1;
            if (req_payload.route_end) begin
               route_open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_open_ff <= 1'b0;
      end else begin
         route_open_ff <= route_open_in;
      end
   end

   assign req_stall = q_full;

endmodule

// ----- src/rpfe_queue.sv -----
// Short command queue between front and back end.
module rpfe_queue import rpfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type q_wr,
   input  logic         q_pop,
   output logic         q_full,
   output queue_rd_type q_rd
);

   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   cmd_type           mem_ff [QUEUE_DEPTH];

   always_comb begin
      count_in = count_ff;
      if (q_wr.push && !q_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (!q_wr.push && q_pop) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (q_wr.push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         mem_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

   assign q_full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_rd.empty = (count_ff == '0);
   assign q_rd.cmd   = mem_ff[rd_ptr_ff];

endmodule

// ----- src/rpfe_back.sv -----
// Back end: segment length, mark stepping, interpolation and the result register.
module rpfe_back import rpfe_pkg::*; #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_rd_type        q_rd,
   output logic                q_pop,
   input  logic [SEARCH_W-1:0] search_distance,
   input  logic [SPACE_W-1:0]  spacing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload
);

   localparam int MARK_W = SEARCH_W + FRACTION_BITS;
   localparam int RCNT_W = $clog2(ROOT_W + 1);

   back_state_type state_ff;
   back_state_type state_in;

   logic [COORD_W-1:0] prev_ff [NUM_AXES];
   logic [COORD_W-1:0] cur_ff  [NUM_AXES];
   logic [DIFF_W-1:0]  dmag_ff [NUM_AXES];
   logic               dneg_ff [NUM_AXES];
   logic [COORD_W-1:0] cmd_pt  [NUM_AXES];
   logic [DIFF_W-1:0]  dmag_in [NUM_AXES];
   logic               dneg_in [NUM_AXES];
   logic               end_ff;

   logic [SQ_STEP_W-1:0] sq_step_ff;
   logic [SQP_W-1:0]     sqp_ff;
   logic                 sqh_ff;
   logic                 sqv_ff;
   logic [SUMSQ_W-1:0]   sumsq_ff;
   logic [1:0]           sq_axis;
   logic [DIFF_W-1:0]    sq_a;
   logic [HALF_W-1:0]    sq_b;

   logic [RAD_W-1:0]   rad_ff;
   logic               big_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [SREM_W-1:0]  srem_ff;
   logic [SREM_W-1:0]  srem_in;
   logic [SREM_W+1:0]  r4;
   logic [SREM_W+1:0]  trial;
   logic               root_ge;
   logic [RCNT_W-1:0]  rcnt_ff;

   logic [LEN_W-1:0]   len_w;
   logic [LEN_W-1:0]   len_ff;
   logic [REACH_W-1:0] reach_ff;
   logic [TRAV_W-1:0]  travelled_ff;
   logic [MARK_W-1:0]  next_mark_ff;
   logic [MARK_W-1:0]  mark_step;
   logic               pending_ff;
   logic               done_ff;

   logic [MARK_W-1:0]  search_q;
   logic [MARK_W-1:0]  space_q;
   logic               fit_cur;
   logic               fit_next;
   logic               slot_free;
   logic               ld_out;
   logic               lane_start;
   logic               lanes_done;
   logic               lanes_busy;
   logic [MARK_W-1:0]  lane_off;
   lane_status_type    lane_st  [NUM_AXES];
   logic [COORD_W-1:0] lane_res [NUM_AXES];

   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            rsp_valid_ff;

   assign search_q  = MARK_W'(search_distance) << FRACTION_BITS;
   assign space_q   = MARK_W'(spacing) << FRACTION_BITS;
   assign mark_step = next_mark_ff + space_q;
   assign fit_cur   = (REACH_W'(next_mark_ff) <= reach_ff) && (next_mark_ff <= search_q);
   assign fit_next  = (REACH_W'(mark_step) <= reach_ff) && (mark_step <= search_q);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign lane_off  = MARK_W'(TRAV_W'(next_mark_ff) - travelled_ff);
   assign len_w     = big_ff ? {root_ff, 1'b0} : {1'b0, root_ff};

   assign cmd_pt[0] = q_rd.cmd.x;
   assign cmd_pt[1] = q_rd.cmd.y;
   assign cmd_pt[2] = q_rd.cmd.z;

   // per-axis difference to the previous point, as magnitude and sign
   always_comb begin
      logic [DIFF_W-1:0] d;
      for (int a = 0; a < NUM_AXES; a++) begin
         d = {cmd_pt[a][COORD_W-1], cmd_pt[a]} - {prev_ff[a][COORD_W-1], prev_ff[a]};
         dneg_in[a] = d[DIFF_W-1];
         dmag_in[a] = d[DIFF_W-1] ? (DIFF_W'(0) - d) : d;
      end
   end

   // squares in halves: a*a = a*a_lo + (a*a_hi << HALF_W)
   always_comb begin
      sq_axis = sq_step_ff[2:1];
      sq_a = (sq_axis == 2'd0) ? dmag_ff[0] : ((sq_axis == 2'd1) ? dmag_ff[1] : dmag_ff[2]);
      sq_b = sq_step_ff[0] ? HALF_W'(sq_a[DIFF_W-1:HALF_W]) : sq_a[HALF_W-1:0];
   end

   // two bits of the radicand per cycle
   always_comb begin
      r4      = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      root_ge = r4 >= trial;
      srem_in = root_ge ? SREM_W'(r4 - trial) : SREM_W'(r4);
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      rpfe_lane #(
         .MARK_W(MARK_W)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .d_mag  (dmag_ff[a]),
         .d_neg  (dneg_ff[a]),
         .base   (prev_ff[a]),
         .off    (lane_off),
         .len    (len_ff),
         .status (lane_st[a]),
         .result (lane_res[a])
      );
   end

   assign lanes_done = lane_st[0].done && lane_st[1].done && lane_st[2].done;
   assign lanes_busy = lane_st[0].busy || lane_st[1].busy || lane_st[2].busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_rd.empty && (q_rd.cmd.op == OP_SEGMENT) && !done_ff) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_step_ff == SQ_STEP_W'(SQ_STEPS)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_ROOT;
         ST_ROOT: begin
            if (rcnt_ff == RCNT_W'(1)) begin
               state_in = ST_REACH;
            end
         end
         ST_REACH: begin
            if (pending_ff) begin
               state_in = ST_END_POINT;
            end else if (len_w == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_END_POINT: begin
            if (slot_free) begin
               state_in = (len_ff == '0) ? ST_FINISH : ST_CHECK;
            end
         end
         ST_CHECK:  state_in = fit_cur ? ST_LERP : ST_FINISH;
         ST_LERP: begin
            if (lanes_done) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            if (slot_free) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop       = 1'b0;
      ld_out      = 1'b0;
      lane_start  = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: q_pop = !q_rd.empty;
         ST_END_POINT: begin
            ld_out = slot_free;
            rsp_data_in.out_x    = prev_ff[0];
            rsp_data_in.out_y    = prev_ff[1];
            rsp_data_in.out_z    = prev_ff[2];
            rsp_data_in.run_last = (len_ff == '0) || !fit_cur;
         end
         ST_CHECK: lane_start = fit_cur;
         ST_POINT: begin
            ld_out = slot_free;
            rsp_data_in.out_x    = lane_res[0];
            rsp_data_in.out_y    = lane_res[1];
            rsp_data_in.out_z    = lane_res[2];
            rsp_data_in.run_last = !fit_next;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         travelled_ff <= '0;
         next_mark_ff <= '0;
         pending_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            prev_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_rd.empty) begin
                  if (q_rd.cmd.op == OP_START) begin
                     // open a route: hold its final point
                     for (int a = 0; a < NUM_AXES; a++) begin
                        prev_ff[a] <= cmd_pt[a];
                     end
                     travelled_ff <= '0;
                     next_mark_ff <= space_q;
                     pending_ff   <= 1'b1;
                     done_ff      <= 1'b0;
                  end else if (done_ff && q_rd.cmd.route_end) begin
                     travelled_ff <= '0;
                     next_mark_ff <= '0;
                     pending_ff   <= 1'b0;
                     done_ff      <= 1'b0;
                  end
               end
            end
            ST_END_POINT: begin
               if (slot_free) begin
                  pending_ff <= 1'b0;
               end
            end
            ST_POINT: begin
               if (slot_free) begin
                  next_mark_ff <= mark_step;
               end
            end
            ST_FINISH: begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  prev_ff[a] <= cur_ff[a];
               end
               if (end_ff) begin
                  travelled_ff <= '0;
                  next_mark_ff <= '0;
                  pending_ff   <= 1'b0;
                  done_ff      <= 1'b0;
               end else if (len_ff != '0) begin
                  travelled_ff <= (reach_ff[REACH_W-1:TRAV_W] != '0) ? '1 :
                                  reach_ff[TRAV_W-1:0];
                  done_ff      <= reach_ff >= REACH_W'(search_q);
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ld_out) begin
         rsp_data_ff <= rsp_data_in;
      end
      unique case (state_ff)
         ST_IDLE: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               cur_ff[a]  <= cmd_pt[a];
               dmag_ff[a] <= dmag_in[a];
               dneg_ff[a] <= dneg_in[a];
            end
            end_ff     <= q_rd.cmd.route_end;
            sq_step_ff <= '0;
            sqv_ff     <= 1'b0;
            sumsq_ff   <= '0;
         end
         ST_SQUARE: begin
            sqp_ff     <= SQP_W'(sq_a) * SQP_W'(sq_b);
            sqh_ff     <= sq_step_ff[0];
            sqv_ff     <= (sq_step_ff != SQ_STEP_W'(SQ_STEPS));
            sq_step_ff <= sq_step_ff + SQ_STEP_W'(1);
            if (sqv_ff) begin
               sumsq_ff <= sumsq_ff + (SUMSQ_W'(sqp_ff) << (sqh_ff ? HALF_W : 0));
            end
         end
         ST_PREP: begin
            // past 64 bits, take the root of a quarter and double it
            big_ff  <= sumsq_ff[SUMSQ_W-1:RAD_W] != '0;
            rad_ff  <= (sumsq_ff[SUMSQ_W-1:RAD_W] != '0) ? sumsq_ff[SUMSQ_W-1:2] :
                       sumsq_ff[RAD_W-1:0];
            root_ff <= '0;
            srem_ff <= '0;
            rcnt_ff <= RCNT_W'(ROOT_W);
         end
         ST_ROOT: begin
            srem_ff <= srem_in;
            root_ff <= {root_ff[ROOT_W-2:0], root_ge};
            rad_ff  <= rad_ff << 2;
            rcnt_ff <= rcnt_ff - RCNT_W'(1);
         end
         ST_REACH: begin
            len_ff   <= len_w;
            reach_ff <= REACH_W'(travelled_ff) + REACH_W'(len_w);
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_rd.empty) else $error("pop from empty queue");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      ld_out |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overwritten");

   a_idle_lanes_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !lanes_busy) else $error("lane busy while idle");

   a_done_needs_route: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (next_mark_ff != '0)) else $error("search done with no route open");

   a_pending_needs_route: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !done_ff) else $error("end point pending after search done");

endmodule
